// File: rtl/core/bve_pkg.sv
`default_nettype none

package bve_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CMP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int MAX_CHARS  = 5;
	localparam int QDEPTH     = 4;
	localparam int QAW        = $clog2(QDEPTH);
	localparam logic [QAW:0] QFULL = QDEPTH[QAW:0];

	localparam logic       REG_FORMAT = 1'b0;
	localparam logic       REG_BUDGET = 1'b1;
	localparam logic       FMT_HEX    = 1'b0;
	localparam logic       FMT_C      = 1'b1;
	localparam logic [15:0] MIN_HEX   = 16'd3;
	localparam logic [15:0] MIN_C     = 16'd5;
	localparam logic [15:0] BUDGET_RST = 16'd256;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_NUL     = 8'h00;

	typedef logic [COUNT_BITS-1:0] cnt_t;

	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [2:0]      n;
	} rend_t;

	// one queued word: every character one item causes, terminator included
	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [2:0]                n;
		logic [15:0]               count;
	} job_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = 8'h30 + {4'h0, d};
		end else begin
			c = 8'h37 + {4'h0, d};
		end
		return c;
	endfunction

	function automatic cnt_t sat_add(input cnt_t a, input logic [2:0] inc);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {{(COUNT_BITS-2){1'b0}}, inc};
		return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
	endfunction

	function automatic rend_t render(input logic fmt, input logic [7:0] b);
		rend_t      r;
		logic [7:0] letter;
		r.chars = '0;
		r.n     = 3'd0;
		letter  = CH_NUL;
		unique case (b)
			8'h07:   letter = 8'h61;
			8'h08:   letter = 8'h62;
			8'h0C:   letter = 8'h66;
			8'h0A:   letter = 8'h6E;
			8'h0D:   letter = 8'h72;
			8'h09:   letter = 8'h74;
			8'h0B:   letter = 8'h76;
			8'h1B:   letter = 8'h65;
			8'h00:   letter = 8'h30;
			default: letter = CH_NUL;
		endcase
		if (fmt == FMT_HEX) begin
			r.chars[0] = hex_char(b[7:4]);
			r.chars[1] = hex_char(b[3:0]);
			r.n        = 3'd2;
		end else if (b == CH_QUOTE || b == CH_BSLASH) begin
			r.chars[0] = CH_BSLASH;
			r.chars[1] = b;
			r.n        = 3'd2;
		end else if (b >= 8'h20 && b <= 8'h7E) begin
			r.chars[0] = b;
			r.n        = 3'd1;
		end else if (letter != CH_NUL) begin
			r.chars[0] = CH_BSLASH;
			r.chars[1] = letter;
			r.n        = 3'd2;
		end else begin
			r.chars[0] = CH_BSLASH;
			r.chars[1] = hex_char({2'b00, b[7:6]});
			r.chars[2] = hex_char({1'b0, b[5:3]});
			r.chars[3] = hex_char({1'b0, b[2:0]});
			r.n        = 3'd4;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/byte_visible_escaper.sv
`default_nettype none
// channel   direction  handshake            payload
// input     in         push / full          byte_present, data_byte, end_of_buffer
// result    out        empty / pop          out_char, run_last, rendered_count
// config    in         cfg_we               cfg_index, cfg_data
//
// The front takes one word a cycle while its 4-word queue has room.
// The back sends one character a cycle while the receiver pops, so an item yields
// 0 to 5 characters: 2 in hex, 1 to 4 in C, one more with the terminator, none
// when the byte is skipped and no terminator follows.
// Reset: format C, budget 256, counters and queue cleared.
// Either side may stall; the queue and the output register absorb it.

module byte_visible_escaper (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         push,
	output logic              full,
	input  wire logic         byte_present,
	input  wire logic [7:0]   data_byte,
	input  wire logic         end_of_buffer,
	output logic              empty,
	input  wire logic         pop,
	output logic [7:0]        out_char,
	output logic              run_last,
	output logic [15:0]       rendered_count
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_empty;
	bve_pkg::job_t  q_wdata;
	bve_pkg::job_t  q_head;

	bve_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.byte_present  (byte_present),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_wdata)
	);

	bve_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.q_empty (q_empty)
	);

	bve_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.out_char       (out_char),
		.run_last       (run_last),
		.rendered_count (rendered_count)
	);

endmodule

`default_nettype wire

// File: rtl/core/bve_front.sv
`default_nettype none

module bve_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic           cfg_index,
	input  wire logic [15:0]    cfg_data,
	input  wire logic           push,
	output logic                full,
	input  wire logic           byte_present,
	input  wire logic [7:0]     data_byte,
	input  wire logic           end_of_buffer,
	input  wire logic           q_full,
	output logic                q_push,
	output bve_pkg::job_t       q_data
);

	logic                          fmt_q;
	logic [15:0]                   budget_q;
	bve_pkg::cnt_t                 chars_q;
	bve_pkg::cnt_t                 bytes_q;
	bve_pkg::cnt_t                 bytes_nxt;
	bve_pkg::rend_t                rend;
	logic [15:0]                   minimum;
	logic [15:0]                   limit;
	logic [bve_pkg::CMP_W-1:0]     limit_w;
	logic [bve_pkg::CMP_W-1:0]     chars_w;
	logic                          budget_ok;
	logic                          render_en;
	logic                          accept;
	logic [2:0]                    n_rend;

	assign full   = q_full;
	assign accept = push && !q_full;

	always_comb begin
		minimum   = (fmt_q == bve_pkg::FMT_HEX) ? bve_pkg::MIN_HEX : bve_pkg::MIN_C;
		budget_ok = budget_q > minimum;
		limit     = budget_q - minimum;
		limit_w   = '0;
		chars_w   = '0;
		limit_w[15:0]                   = limit;
		chars_w[bve_pkg::COUNT_BITS-1:0] = chars_q;
		rend      = bve_pkg::render(fmt_q, data_byte);
		render_en = budget_ok && byte_present && (chars_w < limit_w);
		n_rend    = render_en ? rend.n : 3'd0;
		bytes_nxt = bve_pkg::sat_add(bytes_q, {2'b00, render_en});
		for (int k = 0; k < bve_pkg::MAX_CHARS; k++) begin
			q_data.chars[k] = (k < 4 && 3'(k) < n_rend) ? rend.chars[k[1:0]]
			                                              : bve_pkg::CH_NUL;
		end
		q_data.n     = n_rend + {2'b00, end_of_buffer && budget_ok};
		q_data.count = 16'(bytes_nxt);
		q_push       = accept && budget_ok && (render_en || end_of_buffer);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= bve_pkg::FMT_C;
			budget_q <= bve_pkg::BUDGET_RST;
		end else if (cfg_we) begin
			if (cfg_index == bve_pkg::REG_FORMAT) begin
				fmt_q <= cfg_data[0];
			end else begin
				budget_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
			bytes_q <= '0;
		end else if (accept) begin
			if (end_of_buffer) begin
				chars_q <= '0;
				bytes_q <= '0;
			end else begin
				chars_q <= bve_pkg::sat_add(chars_q, n_rend);
				bytes_q <= bytes_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bve_queue.sv
`default_nettype none

module bve_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire bve_pkg::job_t  wr_data,
	output logic                q_full,
	input  wire logic           rd_en,
	output bve_pkg::job_t       rd_data,
	output logic                q_empty
);

	bve_pkg::job_t              mem_q [bve_pkg::QDEPTH];
	logic [bve_pkg::QAW-1:0]    wr_ptr_q;
	logic [bve_pkg::QAW-1:0]    rd_ptr_q;
	logic [bve_pkg::QAW:0]      cnt_q;
	logic                       do_wr;
	logic                       do_rd;

	assign q_full  = cnt_q == bve_pkg::QFULL;
	assign q_empty = cnt_q == '0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bve_back.sv
`default_nettype none

module bve_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire bve_pkg::job_t  q_head,
	output logic                q_pop,
	output logic                empty,
	input  wire logic           pop,
	output logic [7:0]          out_char,
	output logic                run_last,
	output logic [15:0]         rendered_count
);

	logic        out_vld_q;
	logic [2:0]  idx_q;
	logic        load;
	logic        emit;
	logic        is_last;

	assign load    = !out_vld_q || pop;
	assign emit    = load && !q_empty;
	assign is_last = idx_q == (q_head.n - 3'd1);
	assign q_pop   = emit && is_last;
	assign empty   = !out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			idx_q     <= 3'd0;
		end else begin
			if (load) begin
				out_vld_q <= emit;
			end
			if (emit) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char       <= q_head.chars[idx_q];
			run_last       <= is_last;
			rendered_count <= q_head.count;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bve_checker.sv
`default_nettype none

module bve_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         full,
	input wire logic         empty,
	input wire logic         pop,
	input wire logic [7:0]   out_char,
	input wire logic         run_last,
	input wire logic [15:0]  rendered_count
);

	// a waiting word is not withdrawn
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_char) && $stable(run_last))
		else $error("result word changed while waiting");

	// the rest of a run is already queued, count holds across it
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !run_last |=> !empty && $stable(rendered_count))
		else $error("run broken or count changed mid run");

	// NUL only ever appears as terminator
	a_nul: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_char == 8'h00 |-> run_last)
		else $error("NUL inside a run");

	// nothing visible straight after reset
	a_rst: assert property (@(posedge clk)
		!arst_n |=> empty && !full)
		else $error("not empty after reset");

endmodule

bind byte_visible_escaper bve_checker u_bve_checker (.*);

`default_nettype wire

// File: tb/sv/byte_visible_escaper_tb.sv
`default_nettype none

module byte_visible_escaper_tb;

	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE       = 20;

	typedef struct packed {
		logic       present;
		logic [7:0] data;
		logic       last;
	} src_item_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic [15:0] count;
	} char_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        push;
	logic        full;
	logic        byte_present;
	logic [7:0]  data_byte;
	logic        end_of_buffer;
	logic        empty;
	logic        pop;
	logic [7:0]  out_char;
	logic        run_last;
	logic [15:0] rendered_count;

	src_item_t  pending_items[$];
	char_word_t expected_chars[$];
	src_item_t  drive_item;
	char_word_t got_word;

	logic           fmt_now;
	logic [15:0]    budget_now;
	bve_pkg::cnt_t  chars_written;
	bve_pkg::cnt_t  bytes_rendered;

	int  n_queued;
	int  n_accepted;
	int  errors;
	int  in_gap;
	int  out_gap;
	bit  in_took;
	bit  steady_mode;

	byte_visible_escaper dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.byte_present   (byte_present),
		.data_byte      (data_byte),
		.end_of_buffer  (end_of_buffer),
		.empty          (empty),
		.pop            (pop),
		.out_char       (out_char),
		.run_last       (run_last),
		.rendered_count (rendered_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("byte_visible_escaper regression: fail");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (errors < 100) begin
			$display("MISMATCH @%0t: %s", $realtime, msg);
		end
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h37 + {4'h0, d});
	endfunction

	function automatic bve_pkg::cnt_t bump(input bve_pkg::cnt_t a, input logic [2:0] inc);
		logic [bve_pkg::COUNT_BITS:0] s;
		s = {1'b0, a} + {{(bve_pkg::COUNT_BITS-2){1'b0}}, inc};
		return s[bve_pkg::COUNT_BITS] ? {bve_pkg::COUNT_BITS{1'b1}}
		                              : s[bve_pkg::COUNT_BITS-1:0];
	endfunction

	// expected characters for one accepted word, counters updated in place
	function automatic void escape_item(input src_item_t it);
		logic [15:0]     minimum;
		logic [15:0]     limit;
		logic [4:0][7:0] seq;
		logic [7:0]      b;
		logic [7:0]      letter;
		int              n;
		n       = 0;
		seq     = '0;
		b       = it.data;
		minimum = (fmt_now == bve_pkg::FMT_HEX) ? bve_pkg::MIN_HEX : bve_pkg::MIN_C;
		if (budget_now > minimum) begin
			limit = budget_now - minimum;
			if (it.present && chars_written < limit) begin
				if (fmt_now == bve_pkg::FMT_HEX) begin
					seq[0] = digit_char(b[7:4]);
					seq[1] = digit_char(b[3:0]);
					n      = 2;
				end else if (b == bve_pkg::CH_QUOTE || b == bve_pkg::CH_BSLASH) begin
					seq[0] = bve_pkg::CH_BSLASH;
					seq[1] = b;
					n      = 2;
				end else if (b >= 8'h20 && b <= 8'h7E) begin
					seq[0] = b;
					n      = 1;
				end else begin
					case (b)
						8'h07:   letter = "a";
						8'h08:   letter = "b";
						8'h0C:   letter = "f";
						8'h0A:   letter = "n";
						8'h0D:   letter = "r";
						8'h09:   letter = "t";
						8'h0B:   letter = "v";
						8'h1B:   letter = "e";
						8'h00:   letter = "0";
						default: letter = bve_pkg::CH_NUL;
					endcase
					seq[0] = bve_pkg::CH_BSLASH;
					if (letter != bve_pkg::CH_NUL) begin
						seq[1] = letter;
						n      = 2;
					end else begin
						seq[1] = digit_char({2'b00, b[7:6]});
						seq[2] = digit_char({1'b0, b[5:3]});
						seq[3] = digit_char({1'b0, b[2:0]});
						n      = 4;
					end
				end
				chars_written  = bump(chars_written, 3'(n));
				bytes_rendered = bump(bytes_rendered, 3'd1);
			end
			if (it.last) begin
				seq[n] = bve_pkg::CH_NUL;
				n++;
			end
		end
		for (int k = 0; k < n; k++) begin
			expected_chars.push_back('{ch: seq[k], last: (k == n - 1),
				count: 16'(bytes_rendered)});
		end
		if (it.last) begin
			chars_written  = '0;
			bytes_rendered = '0;
		end
	endfunction

	// check results first, then take the input word of this edge
	always @(posedge clk) begin
		if (arst_n && !empty && pop) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected word char=%h last=%b count=%0d",
					out_char, run_last, rendered_count));
			end else begin
				got_word = expected_chars.pop_front();
				if (out_char !== got_word.ch) begin
					report_mismatch($sformatf("out_char %h, expected %h", out_char, got_word.ch));
				end
				if (run_last !== got_word.last) begin
					report_mismatch($sformatf("run_last %b, expected %b", run_last,
						got_word.last));
				end
				if (rendered_count !== got_word.count) begin
					report_mismatch($sformatf("rendered_count %0d, expected %0d",
						rendered_count, got_word.count));
				end
			end
		end
		if (arst_n && push && !full) begin
			escape_item('{present: byte_present, data: data_byte, last: end_of_buffer});
			n_accepted++;
			in_took <= 1'b1;
		end else begin
			in_took <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!push || in_took) begin
			if (in_gap > 0) begin
				in_gap--;
				push <= 1'b0;
			end else if (pending_items.size() != 0) begin
				drive_item = pending_items.pop_front();
				byte_present  <= drive_item.present;
				data_byte     <= drive_item.data;
				end_of_buffer <= drive_item.last;
				push          <= 1'b1;
				in_gap = steady_mode ? 0 : pick_gap();
			end else begin
				push <= 1'b0;
			end
		end
		if (out_gap > 0) begin
			out_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if (!steady_mode && $urandom_range(0, 3) == 0) begin
				out_gap = pick_gap();
			end
		end
	end

	task automatic add_item(input logic present, input logic [7:0] data, input logic last);
		pending_items.push_back('{present: present, data: data, last: last});
		n_queued++;
	endtask

	task automatic wait_quiet();
		while (n_accepted != n_queued || expected_chars.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// skipped and empty words leave no result behind, so give them time to drain
	task automatic wait_idle();
		wait_quiet();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == bve_pkg::REG_FORMAT) begin
			fmt_now = val[0];
		end else begin
			budget_now = val;
		end
	endtask

	function automatic logic [7:0] random_byte();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 6) begin
			return 8'($urandom_range(8'h20, 8'h7E));
		end else if (sel < 9) begin
			case ($urandom_range(0, 10))
				0:       return 8'h00;
				1:       return 8'h07;
				2:       return 8'h08;
				3:       return 8'h09;
				4:       return 8'h0A;
				5:       return 8'h0B;
				6:       return 8'h0C;
				7:       return 8'h0D;
				8:       return 8'h1B;
				9:       return bve_pkg::CH_QUOTE;
				default: return bve_pkg::CH_BSLASH;
			endcase
		end else if (sel < 14) begin
			return 8'($urandom_range(8'h80, 8'hFF));
		end else if (sel < 17) begin
			return ($urandom_range(0, 4) == 0) ? 8'h7F : 8'($urandom_range(8'h00, 8'h1F));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_buffer();
		int len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		if (len == 0) begin
			add_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
		end
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				add_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
			end
			add_item(1'b1, random_byte(), i == len - 1);
		end
	endtask

	task automatic run_phase(input logic fmt, input logic [15:0] budget, input int n_items,
			input bit pause, input bit steady);
		int start;
		write_reg(bve_pkg::REG_FORMAT, {15'($urandom), fmt});
		write_reg(bve_pkg::REG_BUDGET, budget);
		steady_mode = steady;
		start       = n_queued;
		while (n_queued - start < n_items) begin
			add_buffer();
			if (pause && n_queued - start >= n_items / 2) begin
				wait_quiet();
				pause = 1'b0;
			end
		end
		// sometimes leave a buffer open across the register change
		if ($urandom_range(0, 2) == 0) begin
			for (int i = $urandom_range(1, 3); i > 0; i--) begin
				add_item(1'b1, random_byte(), 1'b0);
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = bve_pkg::REG_FORMAT;
		cfg_data       = '0;
		push           = 1'b0;
		pop            = 1'b0;
		byte_present   = 1'b0;
		data_byte      = '0;
		end_of_buffer  = 1'b0;
		fmt_now        = bve_pkg::FMT_C;
		budget_now     = bve_pkg::BUDGET_RST;
		chars_written  = '0;
		bytes_rendered = '0;
		n_queued       = 0;
		n_accepted     = 0;
		errors         = 0;
		in_gap         = 0;
		out_gap        = 0;
		in_took        = 1'b0;
		steady_mode    = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: every escape class in C syntax
		add_item(1'b1, 8'h00, 1'b0);
		add_item(1'b1, 8'h07, 1'b0);
		add_item(1'b1, 8'h08, 1'b0);
		add_item(1'b1, 8'h09, 1'b0);
		add_item(1'b1, 8'h0A, 1'b0);
		add_item(1'b1, 8'h0B, 1'b0);
		add_item(1'b1, 8'h0C, 1'b0);
		add_item(1'b1, 8'h0D, 1'b0);
		add_item(1'b1, 8'h1B, 1'b0);
		add_item(1'b1, bve_pkg::CH_QUOTE, 1'b0);
		add_item(1'b1, bve_pkg::CH_BSLASH, 1'b0);
		add_item(1'b1, 8'h20, 1'b0);
		add_item(1'b1, 8'h7E, 1'b0);
		add_item(1'b1, 8'h7F, 1'b0);
		add_item(1'b1, 8'h80, 1'b0);
		add_item(1'b1, 8'hFF, 1'b0);
		add_item(1'b1, 8'h01, 1'b0);
		add_item(1'b0, 8'hFF, 1'b0);
		add_item(1'b1, 8'h41, 1'b1);
		add_item(1'b0, 8'h00, 1'b1);
		wait_idle();

		write_reg(bve_pkg::REG_FORMAT, {15'd0, bve_pkg::FMT_HEX});
		add_item(1'b1, 8'h00, 1'b0);
		add_item(1'b1, 8'hFF, 1'b0);
		add_item(1'b1, 8'h5A, 1'b1);
		wait_idle();

		// budget 6 in C: one octal escape fills it, the next byte is skipped
		write_reg(bve_pkg::REG_FORMAT, {15'd0, bve_pkg::FMT_C});
		write_reg(bve_pkg::REG_BUDGET, 16'd6);
		add_item(1'b1, 8'h01, 1'b0);
		add_item(1'b1, 8'h41, 1'b1);
		wait_idle();

		run_phase(bve_pkg::FMT_C,   16'd256,   24, 1'b1, 1'b0);
		run_phase(bve_pkg::FMT_HEX, 16'd256,   16, 1'b0, 1'b1);
		run_phase(bve_pkg::FMT_C,   16'd0,      5, 1'b0, 1'b0);
		run_phase(bve_pkg::FMT_HEX, 16'd3,      5, 1'b0, 1'b0);
		run_phase(bve_pkg::FMT_HEX, 16'd4,      8, 1'b0, 1'b0);
		run_phase(bve_pkg::FMT_C,   16'd5,      5, 1'b0, 1'b0);
		run_phase(bve_pkg::FMT_C,   16'd6,      8, 1'b0, 1'b0);
		run_phase(bve_pkg::FMT_HEX, 16'd65535, 16, 1'b1, 1'b0);
		run_phase(bve_pkg::FMT_C,   16'd65535, 16, 1'b0, 1'b0);
		run_phase(bve_pkg::FMT_C,   16'($urandom_range(7, 40)), 16, 1'b0, 1'b0);
		run_phase(bve_pkg::FMT_HEX, 16'($urandom_range(4, 40)), 16, 1'b0, 1'b1);
		run_phase(bve_pkg::FMT_C,   16'($urandom_range(16'h8000, 16'hFFFE)), 6, 1'b0, 1'b0);

		wait_idle();
		if (expected_chars.size() != 0) begin
			report_mismatch($sformatf("%0d words never arrived", expected_chars.size()));
		end
		if (errors == 0) begin
			$display("byte_visible_escaper regression: pass");
		end else begin
			$display("byte_visible_escaper regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
